[hw/rtl/assert_macros.svh]
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BDAR_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BDAR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/bdar_pkg.sv]
// Types and constants of the button debouncer with auto-repeat.
package bdar_pkg;

  localparam logic [1:0] KIND_RAISING = 2'd0;
  localparam logic [1:0] KIND_PRESSED = 2'd1;
  localparam logic [1:0] KIND_FALLING = 2'd2;

  typedef logic [2:0]  cfg_idx_t;
  typedef logic [15:0] cfg_data_t;

  localparam cfg_idx_t REG_INVERT      = 3'd0;
  localparam cfg_idx_t REG_DEBOUNCE    = 3'd1;
  localparam cfg_idx_t REG_SLOW_REPEAT = 3'd2;
  localparam cfg_idx_t REG_FAST_REPEAT = 3'd3;
  localparam cfg_idx_t REG_SLOW_LIMIT  = 3'd4;

  localparam cfg_data_t DEBOUNCE_RST    = 16'd50;
  localparam cfg_data_t SLOW_REPEAT_RST = 16'd250;
  localparam cfg_data_t FAST_REPEAT_RST = 16'd100;
  localparam cfg_data_t SLOW_LIMIT_RST  = 16'd5;

  localparam logic [15:0] TICKS_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [15:0] repeat_count;
    logic [31:0] event_time;
    logic        level;
    logic        last;
  } evt_t;

  // Results of one sample handed to the output buffer together.
  typedef struct packed {
    logic [1:0] num;
    evt_t       first;
    evt_t       second;
  } push_t;

endpackage

[hw/rtl/bdar_in_if.sv]
// Input channel: one raw button sample and its time stamp.
interface bdar_in_if;
  logic        valid;
  logic        ready;
  logic        raw_level;
  logic [31:0] now_ms;

  modport source (output valid, output raw_level, output now_ms, input ready);
  modport sink (input valid, input raw_level, input now_ms, output ready);
endinterface

[hw/rtl/bdar_out_if.sv]
// Result channel: one button event.
interface bdar_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [15:0] repeat_count;
  logic [31:0] event_time;
  logic        level;
  logic        last;

  modport source (output valid, output event_kind, output repeat_count, output event_time,
                  output level, output last, input ready);
  modport sink (input valid, input event_kind, input repeat_count, input event_time,
                input level, input last, output ready);
endinterface

[hw/rtl/bdar_cfg_if.sv]
// Configuration write channel: register index and write data.
interface bdar_cfg_if;
  logic                valid;
  logic                ready;
  bdar_pkg::cfg_idx_t  index;
  bdar_pkg::cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/bdar_out_buf.sv]
// Two-entry result buffer between the event logic and the result channel.
module bdar_out_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  bdar_pkg::push_t push,
  input  logic            pop_ready,
  output logic            head_valid,
  output bdar_pkg::evt_t  head,
  output logic [1:0]      room
);
  import bdar_pkg::*;

  logic [1:0] cnt_r, cnt_nxt;
  evt_t       ent_r   [2];
  evt_t       ent_nxt [2];
  logic       pop;
  logic [1:0] base;

  assign head_valid = (cnt_r != 2'd0);
  assign head       = ent_r[0];
  assign pop        = head_valid && pop_ready;
  assign base       = cnt_r - {1'b0, pop};
  assign room       = 2'd2 - base;

  always_comb begin
    // advance the queue on a pop, then append behind what stays
    ent_nxt[0] = pop ? ent_r[1] : ent_r[0];
    ent_nxt[1] = ent_r[1];
    if (push.num != 2'd0) begin
      if (base == 2'd0) begin
        ent_nxt[0] = push.first;
        ent_nxt[1] = push.second;
      end else begin
        ent_nxt[1] = push.first;
      end
    end
    cnt_nxt = base + push.num;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r[0] <= ent_nxt[0];
    ent_r[1] <= ent_nxt[1];
  end

endmodule

[hw/rtl/button_debounce_autorepeat.sv]
// Button debouncer with auto-repeat. A sample is taken into an input register and
// handled there; its results (none, one or two events) are written into a two-entry
// output buffer once it has room for them, and they reach the result channel from
// that buffer. A new sample is taken every cycle while the
// buffer has room for the results of the one being handled, so samples with at most
// one event flow at one per cycle while the result channel is ready, and a sample with
// two events (a press: raising then pressed) waits until the buffer has room for both. The
// configuration port is always ready and takes writes to register 0 (invert),
// 1 (debounce_ms), 2 (slow_repeat_ms), 3 (fast_repeat_ms) and 4 (slow_repeat_limit);
// other indexes are ignored. Times are milliseconds modulo 2^32, compared strictly.
module button_debounce_autorepeat (
  input  logic       clk,
  input  logic       rst_n,
  bdar_in_if.sink    in_chan,
  bdar_out_if.source out_chan,
  bdar_cfg_if.sink   cfg_chan
);
  import bdar_pkg::*;

  // configuration
  logic        invert_r;
  logic [15:0] debounce_r, slow_rep_r, fast_rep_r, slow_lim_r;

  // input register
  logic        inv_valid_r;
  logic        raw_r;
  logic [31:0] now_r;

  // debouncer state
  logic        stable_r, prev_r;
  logic [31:0] settle_r, rep_start_r;
  logic [15:0] ticks_r;

  logic        reading, flip, rose, fell, rep;
  logic [31:0] settle_age, rep_age;
  logic [15:0] interval, ticks_inc;
  logic [1:0]  num;
  logic [1:0]  room;
  logic        commit;
  push_t       push;
  evt_t        head;
  logic        head_valid;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r   <= 1'b0;
      debounce_r <= DEBOUNCE_RST;
      slow_rep_r <= SLOW_REPEAT_RST;
      fast_rep_r <= FAST_REPEAT_RST;
      slow_lim_r <= SLOW_LIMIT_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        REG_INVERT:      invert_r   <= cfg_chan.data[0];
        REG_DEBOUNCE:    debounce_r <= cfg_chan.data;
        REG_SLOW_REPEAT: slow_rep_r <= cfg_chan.data;
        REG_FAST_REPEAT: fast_rep_r <= cfg_chan.data;
        REG_SLOW_LIMIT:  slow_lim_r <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // event logic on the registered sample
  always_comb begin
    reading    = raw_r ^ invert_r;
    settle_age = now_r - settle_r;
    // a change of reading restarts the timer, and the sample that changes it gives no flip
    flip       = (reading == prev_r) && (settle_age > {16'd0, debounce_r})
                 && (reading != stable_r);
    rose       = flip && reading;
    fell       = flip && !reading;
    interval   = (ticks_r < slow_lim_r) ? slow_rep_r : fast_rep_r;
    rep_age    = now_r - rep_start_r;
    rep        = !flip && stable_r && (rep_age > {16'd0, interval});
    ticks_inc  = (ticks_r == TICKS_MAX) ? ticks_r : ticks_r + 16'd1;

    if (rose) begin
      num = 2'd2;
    end else if (fell || rep) begin
      num = 2'd1;
    end else begin
      num = 2'd0;
    end

    if (rose) begin
      push.first = '{event_kind: KIND_RAISING, repeat_count: 16'd0, event_time: 32'd0,
                     level: 1'b1, last: 1'b0};
    end else if (fell) begin
      push.first = '{event_kind: KIND_FALLING, repeat_count: ticks_r, event_time: now_r,
                     level: 1'b0, last: 1'b1};
    end else begin
      push.first = '{event_kind: KIND_PRESSED, repeat_count: ticks_inc, event_time: now_r,
                     level: 1'b1, last: 1'b1};
    end
    push.second = '{event_kind: KIND_PRESSED, repeat_count: 16'd0, event_time: now_r,
                    level: 1'b1, last: 1'b1};

    commit   = inv_valid_r && (num <= room);
    push.num = commit ? num : 2'd0;
  end

  assign in_chan.ready = !inv_valid_r || commit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_valid_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      inv_valid_r <= 1'b1;
    end else if (commit) begin
      inv_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      raw_r <= in_chan.raw_level;
      now_r <= in_chan.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r    <= 1'b0;
      prev_r      <= 1'b0;
      settle_r    <= 32'd0;
      rep_start_r <= 32'd0;
      ticks_r     <= 16'd0;
    end else if (commit) begin
      prev_r <= reading;
      if (reading != prev_r) begin
        settle_r <= now_r;
      end
      if (flip) begin
        stable_r <= reading;
      end
      if (rose) begin
        rep_start_r <= now_r;
        ticks_r     <= 16'd0;
      end else if (rep) begin
        rep_start_r <= now_r;
        ticks_r     <= ticks_inc;
      end
    end
  end

  bdar_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop_ready  (out_chan.ready),
    .head_valid (head_valid),
    .head       (head),
    .room       (room)
  );

  assign out_chan.valid        = head_valid;
  assign out_chan.event_kind   = head.event_kind;
  assign out_chan.repeat_count = head.repeat_count;
  assign out_chan.event_time   = head.event_time;
  assign out_chan.level        = head.level;
  assign out_chan.last         = head.last;

endmodule

[hw/rtl/bdar_chk.sv]
// Port-level checker for the button debouncer, bound to the top level.
`include "assert_macros.svh"

module bdar_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_event_kind,
  input logic [15:0] out_repeat_count,
  input logic        out_level,
  input logic        out_last
);
  import bdar_pkg::*;

  // a stalled event stays valid
  `BDAR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // a raising event never ends a sample's results
  `BDAR_ASSERT_NOW(a_raise_not_last, out_valid && (out_event_kind == KIND_RAISING), !out_last)

  // a taken raising event is followed at once by the first pressed event
  `BDAR_ASSERT_NEXT(a_raise_then_press,
                    out_valid && out_ready && (out_event_kind == KIND_RAISING),
                    out_valid && (out_event_kind == KIND_PRESSED) && (out_repeat_count == 16'd0))

  // only a falling event reports the released level
  `BDAR_ASSERT_NOW(a_level_kind, out_valid, out_level == (out_event_kind != KIND_FALLING))

endmodule

bind button_debounce_autorepeat bdar_chk u_bdar_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_event_kind   (out_chan.event_kind),
  .out_repeat_count (out_chan.repeat_count),
  .out_level        (out_chan.level),
  .out_last         (out_chan.last)
);

[bench/button_debounce_autorepeat_tb.sv]
// Self-checking testbench for the button debouncer with auto-repeat.
module button_debounce_autorepeat_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdar_pkg::*;

  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam cfg_idx_t    REG_PAST_END   = REG_SLOW_LIMIT + 3'd1;
  localparam cfg_idx_t    REG_TOP        = '1;

  logic clk = 1'b0;
  logic rst_n;

  bdar_in_if  in_chan ();
  bdar_out_if out_chan ();
  bdar_cfg_if cfg_chan ();

  button_debounce_autorepeat u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always #4 clk = ~clk;

  // Debouncer state mirrored in the bench
  logic        cfg_invert;
  logic [15:0] cfg_debounce;
  logic [15:0] cfg_slow_ms;
  logic [15:0] cfg_fast_ms;
  logic [15:0] cfg_slow_limit;
  logic        deb_level;
  logic        last_reading;
  logic [31:0] settle_t0;
  logic [31:0] repeat_t0;
  logic [15:0] ticks;

  evt_t        pending_events[$];
  int unsigned fail_cnt = 0;
  logic [31:0] cur_ms;
  logic        in_gaps_on   = 1'b0;
  logic        out_stall_on = 1'b0;
  logic        hold_req     = 1'b0;

  function automatic evt_t make_event(logic [1:0] kind, logic [15:0] cnt, logic [31:0] t);
    evt_t ev;
    ev.event_kind   = kind;
    ev.repeat_count = cnt;
    ev.event_time   = t;
    ev.level        = deb_level;
    ev.last         = 1'b0;
    return ev;
  endfunction

  // Advance the mirrored state by one sample and queue the events it causes
  function automatic void predict_events(logic raw, logic [31:0] t);
    logic        reading;
    logic        rose;
    logic        fell;
    logic [31:0] since;
    logic [31:0] interval;
    evt_t        evs[2];
    int          n;
    reading = raw ^ cfg_invert;
    rose = 1'b0;
    fell = 1'b0;
    n = 0;
    if (reading != last_reading) settle_t0 = t;
    since = t - settle_t0;
    if (since > {16'h0, cfg_debounce} && reading != deb_level) begin
      deb_level = reading;
      if (reading) rose = 1'b1;
      else fell = 1'b1;
    end
    last_reading = reading;
    if (rose) begin
      repeat_t0 = t;
      ticks = '0;
      evs[n] = make_event(KIND_RAISING, 16'd0, 32'd0);
      n++;
      evs[n] = make_event(KIND_PRESSED, 16'd0, t);
      n++;
    end
    if (fell) begin
      evs[n] = make_event(KIND_FALLING, ticks, t);
      n++;
    end
    if (deb_level) begin
      interval = (ticks < cfg_slow_limit) ? {16'h0, cfg_slow_ms} : {16'h0, cfg_fast_ms};
      since = t - repeat_t0;
      if (since > interval && n < 2) begin
        if (ticks != TICKS_MAX) ticks++;
        repeat_t0 = t;
        evs[n] = make_event(KIND_PRESSED, ticks, t);
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      evs[i].last = (i == n - 1);
      pending_events.push_back(evs[i]);
    end
  endfunction

  // Offer one sample; valid stays high on return so the next call can follow at once
  task automatic send_sample(logic raw, logic [31:0] t);
    if (in_gaps_on && $urandom_range(0, 4) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.raw_level <= raw;
    in_chan.now_ms    <= t;
    do @(posedge clk); while (!in_chan.ready);
    predict_events(raw, t);
  endtask

  // Drop valid and wait until every queued event has come out
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    do @(posedge clk); while (!cfg_chan.ready);
    case (idx)
      REG_INVERT:      cfg_invert     = val[0];
      REG_DEBOUNCE:    cfg_debounce   = val;
      REG_SLOW_REPEAT: cfg_slow_ms    = val;
      REG_FAST_REPEAT: cfg_fast_ms    = val;
      REG_SLOW_LIMIT:  cfg_slow_limit = val;
      default: ;
    endcase
    cfg_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(logic inv, cfg_data_t deb, cfg_data_t slow, cfg_data_t fast,
                           cfg_data_t lim);
    settle();
    write_reg(REG_INVERT, {15'h0, inv});
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_SLOW_REPEAT, slow);
    write_reg(REG_FAST_REPEAT, fast);
    write_reg(REG_SLOW_LIMIT, lim);
  endtask

  // Presses and releases with contact bounce, plus a little pure noise
  task automatic gesture_stream(int unsigned n_items, int unsigned max_step);
    int unsigned sent;
    int unsigned bounces;
    int unsigned holds;
    logic        lvl;
    sent = 0;
    lvl = 1'b1;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        cur_ms = $urandom();
        send_sample(1'($urandom_range(0, 1)), cur_ms);
        sent++;
      end else begin
        bounces = $urandom_range(0, 3);
        holds = $urandom_range(1, 8);
        repeat (bounces) begin
          cur_ms += $urandom_range(0, 3);
          send_sample(1'($urandom_range(0, 1)), cur_ms);
        end
        repeat (holds) begin
          cur_ms += $urandom_range(0, max_step);
          send_sample(lvl, cur_ms);
        end
        sent += bounces + holds;
        lvl = ~lvl;
      end
    end
  endtask

  // Reset values, time wrap, glitch while held, extremes of the time stamp
  task automatic test_reset_defaults();
    send_sample(1'b0, 32'h0000_0000);
    send_sample(1'b1, 32'hFFFF_FFE0);
    send_sample(1'b1, 32'h0000_0012);
    send_sample(1'b1, 32'h0000_0013);
    cur_ms = 32'h0000_0013;
    send_sample(1'b1, cur_ms + 32'd250);
    cur_ms += 32'd251;
    send_sample(1'b1, cur_ms);
    send_sample(1'b0, cur_ms + 32'd10);
    send_sample(1'b1, cur_ms + 32'd11);
    send_sample(1'b0, 32'hFFFF_FFFF);
    send_sample(1'b0, 32'h0000_0040);
  endtask

  // Inverted pin, zero delays, writes past the last register
  task automatic test_zero_intervals();
    write_all(1'b1, 16'd0, 16'd0, 16'd0, 16'd0);
    write_reg(REG_PAST_END, 16'hFFFF);
    write_reg(REG_TOP, 16'hFFFF);
    send_sample(1'b0, 32'd100);
    send_sample(1'b0, 32'd101);
    send_sample(1'b0, 32'd101);
    send_sample(1'b0, 32'd102);
    send_sample(1'b1, 32'd103);
    send_sample(1'b1, 32'd104);
  endtask

  task automatic test_max_settings();
    write_all(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    cur_ms = 32'd1000;
    send_sample(1'b1, cur_ms);
    cur_ms += 32'd65535;
    send_sample(1'b1, cur_ms);
    cur_ms += 32'd1;
    send_sample(1'b1, cur_ms);
    cur_ms += 32'd65535;
    send_sample(1'b1, cur_ms);
    cur_ms += 32'd1;
    send_sample(1'b1, cur_ms);
    cur_ms += 32'd1;
    send_sample(1'b0, cur_ms);
    cur_ms += 32'd65536;
    send_sample(1'b0, cur_ms);
  endtask

  // Hold the result side off while a held button repeats on its samples
  task automatic test_backpressure();
    write_all(1'b0, 16'd0, 16'd0, 16'd0, 16'd3);
    hold_req = 1'b1;
    repeat (40) begin
      cur_ms += 32'd1;
      send_sample(1'b1, cur_ms);
    end
    cur_ms += 32'd1;
    send_sample(1'b0, cur_ms);
    cur_ms += 32'd1;
    send_sample(1'b0, cur_ms);
  endtask

  task automatic test_random_settings();
    repeat (4) begin
      write_all(1'($urandom_range(0, 1)), 16'($urandom_range(0, 20)),
                16'($urandom_range(0, 40)), 16'($urandom_range(0, 15)),
                16'($urandom_range(0, 6)));
      gesture_stream(60, 12);
    end
    write_all(1'($urandom_range(0, 1)), 16'($urandom_range(60000, 65535)),
              16'($urandom()), 16'($urandom()), 16'($urandom_range(0, 3)));
    gesture_stream(30, 70000);
  endtask

  task automatic test_random_flat();
    write_all(1'($urandom_range(0, 1)), 16'($urandom_range(0, 10)),
              16'($urandom_range(0, 30)), 16'($urandom_range(0, 10)),
              16'($urandom_range(0, 4)));
    gesture_stream(60, 8);
  endtask

  initial begin : stimulus
    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.raw_level <= 1'b0;
    in_chan.now_ms    <= '0;
    cfg_chan.valid    <= 1'b0;
    cfg_chan.index    <= REG_INVERT;
    cfg_chan.data     <= '0;
    cfg_invert     = 1'b0;
    cfg_debounce   = DEBOUNCE_RST;
    cfg_slow_ms    = SLOW_REPEAT_RST;
    cfg_fast_ms    = FAST_REPEAT_RST;
    cfg_slow_limit = SLOW_LIMIT_RST;
    deb_level      = 1'b0;
    last_reading   = 1'b0;
    settle_t0      = '0;
    repeat_t0      = '0;
    ticks          = '0;
    cur_ms         = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_gaps_on   = 1'b1;
    out_stall_on = 1'b1;
    test_reset_defaults();
    test_zero_intervals();
    test_max_settings();
    test_backpressure();
    test_random_settings();

    in_gaps_on   = 1'b0;
    out_stall_on = 1'b0;
    test_random_flat();

    settle();
    repeat (8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("button_debounce_autorepeat: match");
    end else begin
      $display("button_debounce_autorepeat: mismatch");
    end
    $finish;
  end

  initial begin : result_sink
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (out_stall_on && $urandom_range(0, 4) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    evt_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_events.size() == 0) begin
        $error("event_kind: expected none, actual %0d", out_chan.event_kind);
        fail_cnt++;
      end else begin
        want = pending_events.pop_front();
        if (out_chan.event_kind !== want.event_kind) begin
          $error("event_kind: expected %0d, actual %0d", want.event_kind, out_chan.event_kind);
          fail_cnt++;
        end
        if (out_chan.repeat_count !== want.repeat_count) begin
          $error("repeat_count: expected %0d, actual %0d", want.repeat_count,
                 out_chan.repeat_count);
          fail_cnt++;
        end
        if (out_chan.event_time !== want.event_time) begin
          $error("event_time: expected %0d, actual %0d", want.event_time, out_chan.event_time);
          fail_cnt++;
        end
        if (out_chan.level !== want.level) begin
          $error("level: expected %0d, actual %0d", want.level, out_chan.level);
          fail_cnt++;
        end
        if (out_chan.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_chan.last);
          fail_cnt++;
        end
      end
    end
  end

  // End the run if no handshake completes for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
          (cfg_chan.valid && cfg_chan.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("button_debounce_autorepeat: mismatch");
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/bdar_pkg.sv
hw/rtl/bdar_in_if.sv
hw/rtl/bdar_out_if.sv
hw/rtl/bdar_cfg_if.sv
hw/rtl/bdar_out_buf.sv
hw/rtl/button_debounce_autorepeat.sv
hw/rtl/bdar_chk.sv
bench/button_debounce_autorepeat_tb.sv
